// ===== src/complex_arithmetic_unit_top_macros.svh =====
// ---------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared assertion forms, clocked on clock; the same-cycle form uses reset as the disable
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication, off while reset is high
`define CAU_CHECK_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, active during reset too
`define CAU_CHECK_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// ---------------------------------------------------------------------------
// cau_pkg
// widths, opcodes and pipeline payload types of the complex arithmetic unit
// ---------------------------------------------------------------------------
package cau_pkg;

   localparam int DataWidth = 16;
   localparam int FracBits  = 8;

   // derived widths
   localparam int ProdWidth = 2 * DataWidth;
   localparam int SumWidth  = ProdWidth + 1;
   localparam int DirWidth  = SumWidth;
   localparam int MagWidth  = SumWidth + FracBits;
   localparam int DenWidth  = ProdWidth;
   localparam int QuoWidth  = DataWidth;
   localparam int ShWidth   = DenWidth + QuoWidth - 1;
   localparam int CmpWidth  = (MagWidth > DenWidth + QuoWidth) ? MagWidth
                                                               : DenWidth + QuoWidth;

   // saturation limits as raw bit patterns
   localparam logic [DataWidth-1:0] ResMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] ResMin = {1'b1, {(DataWidth-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   // products stage
   typedef struct packed {
      opcode_type                  op;
      logic signed [ProdWidth-1:0] p_rr;
      logic signed [ProdWidth-1:0] p_ii;
      logic signed [ProdWidth-1:0] p_ri;
      logic signed [ProdWidth-1:0] p_ir;
      logic [ProdWidth-1:0]        p_br2;
      logic [ProdWidth-1:0]        p_bi2;
      logic signed [DirWidth-1:0]  sum_re;
      logic signed [DirWidth-1:0]  sum_im;
   } prod_type;

   // one quotient lane
   typedef struct packed {
      logic [MagWidth-1:0] rem;
      logic [QuoWidth-1:0] quo;
      logic                neg;
      logic                big;
   } lane_type;

   // divider chain payload
   typedef struct packed {
      opcode_type                 op;
      logic                       dz;
      logic [ShWidth-1:0]         dsh;
      lane_type                   re;
      lane_type                   im;
      logic signed [DirWidth-1:0] dir_re;
      logic signed [DirWidth-1:0] dir_im;
   } div_type;

   typedef struct packed {
      logic [DataWidth-1:0] res_real;
      logic [DataWidth-1:0] res_imag;
      logic                 overflow;
      logic                 div_zero;
   } result_type;

endpackage

// ===== src/cau_channels.sv =====
// ---------------------------------------------------------------------------
// cau channels
// valid/ready channels for operand beats and result beats
// ---------------------------------------------------------------------------
interface cau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic signed [cau_pkg::DataWidth-1:0] a_real;
   logic signed [cau_pkg::DataWidth-1:0] a_imag;
   logic signed [cau_pkg::DataWidth-1:0] b_real;
   logic signed [cau_pkg::DataWidth-1:0] b_imag;

   modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cau_pkg::DataWidth-1:0] res_real;
   logic signed [cau_pkg::DataWidth-1:0] res_imag;
   logic                                 overflow;
   logic                                 div_zero;

   modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
   modport sink (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

// ===== src/complex_arithmetic_unit_top.sv =====
// ---------------------------------------------------------------------------
// complex_arithmetic_unit_top
// complex add, subtract, multiply and divide on signed Q8.8 operands
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one operation per beat: opcode and operands a, b.
//   rsp_bus returns one result beat per request, in request order, with
//   saturated real/imaginary parts, an overflow flag and a divide-by-zero
//   flag (results forced to zero then).
//   A request beat passes one product stage, one prep stage, a chain of
//   16 divider cells (one quotient bit each) and the output register.
//   Every operation takes the same path, so order is kept. Throughput is
//   one beat per cycle while rsp_bus does not stall; the divider chain
//   sets the depth.
//   Each stage has its own valid bit and loads whenever it is empty or
//   the stage after it moves, so bubbles close up while rsp_bus stalls and
//   req_bus.ready stays high until every stage holds a beat.
//   Synchronous reset empties all stages; no item is lost or invented
//   across a stall since a full stage holds until its successor moves.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_macros.svh"

module complex_arithmetic_unit_top (
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink   req_bus,
   cau_rsp_if.source rsp_bus
);

   localparam int Cells = cau_pkg::QuoWidth;

   logic                mul_valid, prep_valid, out_valid;
   logic                en_mul, en_prep, en_out;
   cau_pkg::prod_type   mul_data;
   cau_pkg::div_type    prep_data;
   cau_pkg::result_type out_data;
   logic [Cells-1:0]    cell_valid, en_cell;
   cau_pkg::div_type    cell_data [Cells];

   // stage enables, back to front
   assign en_out  = !out_valid || rsp_bus.ready;
   assign en_prep = !prep_valid || en_cell[0];
   assign en_mul  = !mul_valid || en_prep;
   assign req_bus.ready = en_mul;

   // products
   cau_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en_mul),
      .in_valid  (req_bus.valid),
      .in_op     (cau_pkg::opcode_type'(req_bus.opcode)),
      .in_a_real (req_bus.a_real),
      .in_a_imag (req_bus.a_imag),
      .in_b_real (req_bus.b_real),
      .in_b_imag (req_bus.b_imag),
      .valid_ff  (mul_valid),
      .data_ff   (mul_data)
   );

   // sums, divisor and dividend setup
   cau_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en_prep),
      .in_valid (mul_valid),
      .in_data  (mul_data),
      .valid_ff (prep_valid),
      .data_ff  (prep_data)
   );

   // divider chain, one quotient bit per cell
   for (genvar k = 0; k < Cells; k++) begin : g_cell
      if (k == Cells - 1) begin : g_last
         assign en_cell[k] = !cell_valid[k] || en_out;
      end else begin : g_mid
         assign en_cell[k] = !cell_valid[k] || en_cell[k+1];
      end

      if (k == 0) begin : g_first
         cau_div_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en_cell[k]),
            .in_valid (prep_valid),
            .in_data  (prep_data),
            .valid_ff (cell_valid[k]),
            .data_ff  (cell_data[k])
         );
      end else begin : g_next
         cau_div_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en_cell[k]),
            .in_valid (cell_valid[k-1]),
            .in_data  (cell_data[k-1]),
            .valid_ff (cell_valid[k]),
            .data_ff  (cell_data[k])
         );
      end
   end

   // output register
   cau_out u_out (
      .clock    (clock),
      .reset    (reset),
      .en       (en_out),
      .in_valid (cell_valid[Cells-1]),
      .in_data  (cell_data[Cells-1]),
      .valid_ff (out_valid),
      .data_ff  (out_data)
   );

   assign rsp_bus.valid    = out_valid;
   assign rsp_bus.res_real = out_data.res_real;
   assign rsp_bus.res_imag = out_data.res_imag;
   assign rsp_bus.overflow = out_data.overflow;
   assign rsp_bus.div_zero = out_data.div_zero;

   // checks
   `CAU_CHECK_IMP(a_dz_clean, rsp_bus.valid && rsp_bus.div_zero, !rsp_bus.overflow && rsp_bus.res_real == '0 && rsp_bus.res_imag == '0, "divide by zero result not zero")
   `CAU_CHECK_IMP(a_ovf_clamped, rsp_bus.valid && rsp_bus.overflow, rsp_bus.res_real == cau_pkg::ResMax || rsp_bus.res_real == cau_pkg::ResMin || rsp_bus.res_imag == cau_pkg::ResMax || rsp_bus.res_imag == cau_pkg::ResMin, "overflow without clamped part")
   `CAU_CHECK_NXT(a_reset_empty, reset, !rsp_bus.valid && !mul_valid && !prep_valid && cell_valid == '0, "pipeline not empty after reset")

endmodule

// ===== src/cau_mult.sv =====
// ---------------------------------------------------------------------------
// cau_mult
// first stage: all operand products plus the add/subtract result
// ---------------------------------------------------------------------------
module cau_mult (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  cau_pkg::opcode_type                  in_op,
   input  logic signed [cau_pkg::DataWidth-1:0] in_a_real,
   input  logic signed [cau_pkg::DataWidth-1:0] in_a_imag,
   input  logic signed [cau_pkg::DataWidth-1:0] in_b_real,
   input  logic signed [cau_pkg::DataWidth-1:0] in_b_imag,
   output logic                                 valid_ff,
   output cau_pkg::prod_type                    data_ff
);

   cau_pkg::prod_type data_in;
   logic signed [cau_pkg::ProdWidth-1:0] ar_x, ai_x, br_x, bi_x;
   logic signed [cau_pkg::ProdWidth-1:0] br2, bi2;

   // sign-extended operands and products
   always_comb begin
      ar_x = cau_pkg::ProdWidth'(in_a_real);
      ai_x = cau_pkg::ProdWidth'(in_a_imag);
      br_x = cau_pkg::ProdWidth'(in_b_real);
      bi_x = cau_pkg::ProdWidth'(in_b_imag);
      br2  = br_x * br_x;
      bi2  = bi_x * bi_x;
      data_in.op    = in_op;
      data_in.p_rr  = ar_x * br_x;
      data_in.p_ii  = ai_x * bi_x;
      data_in.p_ri  = ar_x * bi_x;
      data_in.p_ir  = ai_x * br_x;
      data_in.p_br2 = br2;
      data_in.p_bi2 = bi2;
      if (in_op == cau_pkg::OP_SUB) begin
         data_in.sum_re = cau_pkg::DirWidth'(in_a_real) - cau_pkg::DirWidth'(in_b_real);
         data_in.sum_im = cau_pkg::DirWidth'(in_a_imag) - cau_pkg::DirWidth'(in_b_imag);
      end else begin
         data_in.sum_re = cau_pkg::DirWidth'(in_a_real) + cau_pkg::DirWidth'(in_b_real);
         data_in.sum_im = cau_pkg::DirWidth'(in_a_imag) + cau_pkg::DirWidth'(in_b_imag);
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/cau_prep.sv =====
// ---------------------------------------------------------------------------
// cau_prep
// second stage: multiply result, divisor, dividend magnitudes, range check
// ---------------------------------------------------------------------------
module cau_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::prod_type in_data,
   output logic              valid_ff,
   output cau_pkg::div_type  data_ff
);

   cau_pkg::div_type data_in;
   logic signed [cau_pkg::SumWidth-1:0] num_re, num_im, mul_re, mul_im;
   logic [cau_pkg::SumWidth-1:0]        abs_re, abs_im;
   logic [cau_pkg::MagWidth-1:0]        mag_re, mag_im;
   logic [cau_pkg::DenWidth-1:0]        den;
   logic [cau_pkg::CmpWidth-1:0]        den_top;

   always_comb begin
      // full-precision sums of products
      num_re = cau_pkg::SumWidth'(in_data.p_rr) + cau_pkg::SumWidth'(in_data.p_ii);
      num_im = cau_pkg::SumWidth'(in_data.p_ir) - cau_pkg::SumWidth'(in_data.p_ri);
      mul_re = cau_pkg::SumWidth'(in_data.p_rr) - cau_pkg::SumWidth'(in_data.p_ii);
      mul_im = cau_pkg::SumWidth'(in_data.p_ri) + cau_pkg::SumWidth'(in_data.p_ir);
      den    = in_data.p_br2 + in_data.p_bi2;

      // dividend magnitudes scaled by the fraction bits
      abs_re = num_re[cau_pkg::SumWidth-1] ? -num_re : num_re;
      abs_im = num_im[cau_pkg::SumWidth-1] ? -num_im : num_im;
      mag_re = cau_pkg::MagWidth'(abs_re) << cau_pkg::FracBits;
      mag_im = cau_pkg::MagWidth'(abs_im) << cau_pkg::FracBits;
      den_top = cau_pkg::CmpWidth'(den) << cau_pkg::QuoWidth;

      data_in.op     = in_data.op;
      data_in.dz     = (den == '0);
      data_in.dsh    = cau_pkg::ShWidth'(den) << (cau_pkg::QuoWidth - 1);
      data_in.re.rem = mag_re;
      data_in.re.quo = '0;
      data_in.re.neg = num_re[cau_pkg::SumWidth-1];
      data_in.re.big = (cau_pkg::CmpWidth'(mag_re) >= den_top);
      data_in.im.rem = mag_im;
      data_in.im.quo = '0;
      data_in.im.neg = num_im[cau_pkg::SumWidth-1];
      data_in.im.big = (cau_pkg::CmpWidth'(mag_im) >= den_top);

      // floor shift of products, or the add/subtract result
      if (in_data.op == cau_pkg::OP_MUL) begin
         data_in.dir_re = mul_re >>> cau_pkg::FracBits;
         data_in.dir_im = mul_im >>> cau_pkg::FracBits;
      end else begin
         data_in.dir_re = in_data.sum_re;
         data_in.dir_im = in_data.sum_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/cau_div_cell.sv =====
// ---------------------------------------------------------------------------
// cau_div_cell
// one restoring-division step: one quotient bit for each lane
// ---------------------------------------------------------------------------
module cau_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cau_pkg::div_type in_data,
   output logic             valid_ff,
   output cau_pkg::div_type data_ff
);

   cau_pkg::div_type data_in;
   logic [cau_pkg::CmpWidth-1:0] dsh_x, rem_re_x, rem_im_x;
   logic                         ge_re, ge_im;

   always_comb begin
      dsh_x    = cau_pkg::CmpWidth'(in_data.dsh);
      rem_re_x = cau_pkg::CmpWidth'(in_data.re.rem);
      rem_im_x = cau_pkg::CmpWidth'(in_data.im.rem);
      ge_re    = (rem_re_x >= dsh_x);
      ge_im    = (rem_im_x >= dsh_x);

      data_in        = in_data;
      data_in.dsh    = in_data.dsh >> 1;
      // trial subtract, keep the remainder when it fits
      data_in.re.rem = ge_re ? cau_pkg::MagWidth'(rem_re_x - dsh_x) : in_data.re.rem;
      data_in.im.rem = ge_im ? cau_pkg::MagWidth'(rem_im_x - dsh_x) : in_data.im.rem;
      data_in.re.quo = {in_data.re.quo[cau_pkg::QuoWidth-2:0], ge_re};
      data_in.im.quo = {in_data.im.quo[cau_pkg::QuoWidth-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/cau_out.sv =====
// ---------------------------------------------------------------------------
// cau_out
// output register: sign and saturation of each part, status flags
// ---------------------------------------------------------------------------
module cau_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  cau_pkg::div_type    in_data,
   output logic                valid_ff,
   output cau_pkg::result_type data_ff
);

   typedef struct packed {
      logic [cau_pkg::DataWidth-1:0] value;
      logic                          ovf;
   } part_type;

   cau_pkg::result_type data_in;
   part_type            part_re, part_im;
   logic                is_div;

   // clamp a wide signed value to the result range
   function automatic part_type sat_dir(input logic signed [cau_pkg::DirWidth-1:0] x);
      part_type r;
      logic signed [cau_pkg::DirWidth-1:0] hi, lo;
      hi = $signed(cau_pkg::DirWidth'(cau_pkg::ResMax));
      lo = $signed({{(cau_pkg::DirWidth-cau_pkg::DataWidth){1'b1}}, cau_pkg::ResMin});
      if (x > hi) begin
         r.value = cau_pkg::ResMax;
         r.ovf   = 1'b1;
      end else if (x < lo) begin
         r.value = cau_pkg::ResMin;
         r.ovf   = 1'b1;
      end else begin
         r.value = x[cau_pkg::DataWidth-1:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

   // apply sign to a quotient magnitude, clamping on overflow
   function automatic part_type sat_quo(input cau_pkg::lane_type l);
      part_type r;
      if (l.neg) begin
         if (l.big || l.quo > cau_pkg::ResMin) begin
            r.value = cau_pkg::ResMin;
            r.ovf   = 1'b1;
         end else begin
            r.value = ~l.quo + 1'b1;
            r.ovf   = 1'b0;
         end
      end else begin
         if (l.big || l.quo > cau_pkg::ResMax) begin
            r.value = cau_pkg::ResMax;
            r.ovf   = 1'b1;
         end else begin
            r.value = l.quo;
            r.ovf   = 1'b0;
         end
      end
      return r;
   endfunction

   always_comb begin
      is_div = (in_data.op == cau_pkg::OP_DIV);
      if (is_div && in_data.dz) begin
         part_re = '0;
         part_im = '0;
      end else if (is_div) begin
         part_re = sat_quo(in_data.re);
         part_im = sat_quo(in_data.im);
      end else begin
         part_re = sat_dir(in_data.dir_re);
         part_im = sat_dir(in_data.dir_im);
      end
      data_in.res_real = part_re.value;
      data_in.res_imag = part_im.value;
      data_in.overflow = part_re.ovf | part_im.ovf;
      data_in.div_zero = is_div & in_data.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== verif/tb_complex_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_complex_arithmetic_unit_top
// drives random and corner operand beats with random gaps, predicts each
// complex result in the testbench and compares it field by field in order
// ---------------------------------------------------------------------------
module tb_complex_arithmetic_unit_top;

   typedef struct {
      cau_pkg::opcode_type op;
      logic [15:0]         ar, ai, br, bi;
   } operation_type;

   typedef struct {
      logic [15:0] re, im;
      logic        ovf, dz;
   } complex_result_type;

   logic clock;
   logic reset;
   cau_req_if req_bus ();
   cau_rsp_if rsp_bus ();

   complex_arithmetic_unit_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   operation_type      pending_ops[$];
   complex_result_type expected_results[$];
   int                 error_count = 0;
   bit                 stimulus_done = 0;
   bit                 drain_pause = 0;
   int                 send_wait = 0;
   int                 recv_wait = 0;

   // clock generation
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // floor division by 2^FracBits
   function automatic longint floor_scale(longint x);
      return x >>> cau_pkg::FracBits;
   endfunction

   function automatic longint clamp_part(longint x, ref bit ovf);
      if (x > 32767) begin
         ovf = 1;
         return 32767;
      end
      if (x < -32768) begin
         ovf = 1;
         return -32768;
      end
      return x;
   endfunction

   function automatic complex_result_type complex_compute(operation_type t);
      complex_result_type r;
      longint ar, ai, br, bi, re, im, den;
      bit ovf;
      ar = longint'($signed(t.ar));
      ai = longint'($signed(t.ai));
      br = longint'($signed(t.br));
      bi = longint'($signed(t.bi));
      re = 0;
      im = 0;
      ovf = 0;
      r.dz = 1'b0;
      case (t.op)
         cau_pkg::OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         cau_pkg::OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         cau_pkg::OP_MUL: begin
            re = floor_scale(ar * br - ai * bi);
            im = floor_scale(ar * bi + ai * br);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) r.dz = 1'b1;
            else begin
               // signed division truncates toward zero
               re = ((ar * br + ai * bi) * (64'sd1 << cau_pkg::FracBits)) / den;
               im = ((ai * br - ar * bi) * (64'sd1 << cau_pkg::FracBits)) / den;
            end
         end
      endcase
      re = clamp_part(re, ovf);
      im = clamp_part(im, ovf);
      r.re = re[15:0];
      r.im = im[15:0];
      r.ovf = ovf;
      return r;
   endfunction

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 512)) - 256);
         4, 5: return 16'(int'($urandom_range(0, 2048)) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.opcode <= '0;
         req_bus.a_real <= '0;
         req_bus.a_imag <= '0;
         req_bus.b_real <= '0;
         req_bus.b_imag <= '0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // hold the beat
      end else if (send_wait > 0) begin
         req_bus.valid <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (drain_pause && expected_results.size() != 0) begin
         req_bus.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
         operation_type t;
         t = pending_ops.pop_front();
         req_bus.valid  <= 1'b1;
         req_bus.opcode <= t.op;
         req_bus.a_real <= t.ar;
         req_bus.a_imag <= t.ai;
         req_bus.b_real <= t.br;
         req_bus.b_imag <= t.bi;
         expected_results.push_back(complex_compute(t));
         send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            complex_result_type e;
            if (expected_results.size() == 0) begin
               $error("unexpected result beat");
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_bus.res_real !== e.re) begin
                  $error("res_real exp %h got %h", e.re, rsp_bus.res_real);
                  error_count++;
               end
               if (rsp_bus.res_imag !== e.im) begin
                  $error("res_imag exp %h got %h", e.im, rsp_bus.res_imag);
                  error_count++;
               end
               if (rsp_bus.overflow !== e.ovf) begin
                  $error("overflow exp %b got %b", e.ovf, rsp_bus.overflow);
                  error_count++;
               end
               if (rsp_bus.div_zero !== e.dz) begin
                  $error("div_zero exp %b got %b", e.dz, rsp_bus.div_zero);
                  error_count++;
               end
            end
         end
         if (recv_wait > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready && $urandom_range(0, 3) == 0)
               recv_wait <= $urandom_range(0, 19);
         end
      end
   end

   task automatic add_op(cau_pkg::opcode_type op, logic [15:0] ar, ai, br, bi);
      operation_type t;
      t.op = op;
      t.ar = ar;
      t.ai = ai;
      t.br = br;
      t.bi = bi;
      pending_ops.push_back(t);
   endtask

   // stimulus
   initial begin
      operation_type t;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every operation, saturation, zero divisor
      add_op(cau_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      add_op(cau_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(cau_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
      add_op(cau_pkg::OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      add_op(cau_pkg::OP_SUB, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
      add_op(cau_pkg::OP_SUB, 16'h1234, 16'h4321, 16'h1111, 16'h2222);
      add_op(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(cau_pkg::OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      add_op(cau_pkg::OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
      add_op(cau_pkg::OP_MUL, 16'h0180, 16'hff40, 16'h0200, 16'h0100);
      add_op(cau_pkg::OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
      add_op(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      add_op(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_op(cau_pkg::OP_DIV, 16'hff00, 16'h0300, 16'h0200, 16'hff00);
      add_op(cau_pkg::OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h7fff);
      add_op(cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
      add_op(cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      wait (pending_ops.size() == 0);

      // pause until the pipeline has drained
      drain_pause = 1;
      @(posedge clock);
      wait (expected_results.size() == 0);
      @(posedge clock);
      drain_pause = 0;

      // random part: bursts with random idle gaps mixed in
      for (int i = 0; i < 1500; i++) begin
         t.op = cau_pkg::opcode_type'($urandom_range(0, 3));
         t.ar = pick_operand();
         t.ai = pick_operand();
         t.br = pick_operand();
         t.bi = pick_operand();
         if (t.op == cau_pkg::OP_DIV && $urandom_range(0, 19) == 0) begin
            t.br = '0;
            t.bi = '0;
         end
         pending_ops.push_back(t);
      end
      wait (pending_ops.size() == 0);
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
